// ===== rtl/lss_pkg.sv =====
package lss_pkg;

  localparam int unsigned DefMaxNx = 32;
  localparam int unsigned DefMaxNy = 32;
  localparam int unsigned DefMaxNz = 32;

  localparam int unsigned CoordW = 10;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 32;

  typedef enum logic [1:0] {
    RANK_NONE,
    RANK_LINE,
    RANK_PLANE,
    RANK_VOLUME
  } rank_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_RANK,
    CFG_SIZE_X,
    CFG_SIZE_Y,
    CFG_SIZE_Z,
    CFG_GHOST,
    CFG_COEF_X,
    CFG_COEF_Y,
    CFG_COEF_Z
  } cfg_idx_e;

  typedef struct packed {
    rank_e       rank;
    logic [5:0]  size_x;
    logic [5:0]  size_y;
    logic [5:0]  size_z;
    logic [3:0]  ghost;
    logic [31:0] coef_x;
    logic [31:0] coef_y;
    logic [31:0] coef_z;
  } cfg_t;

  localparam cfg_t CfgReset = '{
    rank:   RANK_VOLUME,
    size_x: 6'd32,
    size_y: 6'd32,
    size_z: 6'd32,
    ghost:  4'd1,
    coef_x: 32'd65536,
    coef_y: 32'd65536,
    coef_z: 32'd65536
  };

  typedef struct packed {
    logic signed [31:0] sample_value;
    logic               grid_end;
  } in_req_t;

  typedef struct packed {
    logic signed [31:0] laplacian_value;
    logic [4:0]         point_x;
    logic [4:0]         point_y;
    logic [4:0]         point_z;
    logic               final_point;
  } out_req_t;

  // One accepted sample after the plane reads have been issued.
  typedef struct packed {
    rank_e              rank;
    logic               emit;
    logic               row_start;
    logic               fin;
    logic [4:0]         px;
    logic [4:0]         py;
    logic [4:0]         pz;
    logic signed [31:0] sample;
    logic signed [31:0] lw0;
    logic signed [31:0] lw1;
  } s1_t;

  // Read data from the plane store for one sample.
  typedef struct packed {
    logic signed [31:0] row;
    logic signed [31:0] alt;
    logic signed [31:0] ym;
    logic signed [31:0] back;
  } rd_t;

endpackage

// ===== rtl/lss_ram.sv =====
module lss_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 2048
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [$clog2(Depth)-1:0]   waddr_i,
  input  logic [Width-1:0]           wdata_i,
  input  logic                       re_i,
  input  logic [$clog2(Depth)-1:0]   raddr_a_i,
  input  logic [$clog2(Depth)-1:0]   raddr_b_i,
  output logic [Width-1:0]           rdata_a_o,
  output logic [Width-1:0]           rdata_b_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_a_q;
  logic [Width-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_a_q <= mem_q[raddr_a_i];
      rdata_b_q <= mem_q[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

// ===== rtl/lss_front.sv =====
module lss_front #(
  parameter int unsigned MAX_NX = 32,
  parameter int unsigned MAX_NY = 32,
  parameter int unsigned MAX_NZ = 32,
  parameter int unsigned AW = 11
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  lss_pkg::in_req_t in_req_i,
  input  lss_pkg::cfg_t    cfg_i,
  input  logic             s1_ready_i,
  output logic             s1_valid_o,
  output lss_pkg::s1_t     s1_o,
  output logic             ram_en_o,
  output logic [AW-1:0]    waddr_o,
  output logic [AW-1:0]    raddr_row_o,
  output logic [AW-1:0]    raddr_alt_o,
  output logic [AW-1:0]    raddr_ym_o,
  output logic [AW-1:0]    raddr_back_o
);
  import lss_pkg::*;

  localparam int unsigned XW = $clog2(MAX_NX);
  localparam int unsigned YW = (MAX_NY > 1) ? $clog2(MAX_NY) : 1;
  localparam int unsigned ZW = (MAX_NZ > 1) ? $clog2(MAX_NZ) : 1;

  function automatic logic [CoordW-1:0] clamp_dim(input logic [5:0] v,
                                                  input logic [CoordW-1:0] mx);
    logic [CoordW-1:0] w;
    w = CoordW'(v);
    if (w == '0) begin
      return CoordW'(1);
    end
    if (w > mx) begin
      return mx;
    end
    return w;
  endfunction

  function automatic logic in_span(input logic [CoordW-1:0] c,
                                   input logic [CoordW-1:0] g,
                                   input logic [CoordW-1:0] n);
    return (c >= g) && ((c + g) < n);
  endfunction

  logic [XW-1:0] pos_x_q, pos_x_d;
  logic [YW-1:0] pos_y_q, pos_y_d;
  logic [ZW-1:0] pos_z_q, pos_z_d;
  logic signed [31:0] lw0_q, lw1_q;
  logic s1_valid_q;
  s1_t  s1_q, s1_d;
  logic accept;
  logic [CoordW-1:0] nx, ny, nz, g, x, y, z, cx, cy, cz;
  logic ix, iy, iz;
  logic [XW-1:0] xp1;
  logic [YW-1:0] ym1, ym2, yp1;
  logic zp;

  assign in_ready_o = !s1_valid_q || s1_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    nx = clamp_dim(cfg_i.size_x, CoordW'(MAX_NX));
    ny = (cfg_i.rank == RANK_PLANE || cfg_i.rank == RANK_VOLUME) ?
         clamp_dim(cfg_i.size_y, CoordW'(MAX_NY)) : CoordW'(1);
    nz = (cfg_i.rank == RANK_VOLUME) ? clamp_dim(cfg_i.size_z, CoordW'(MAX_NZ)) : CoordW'(1);
    g  = (cfg_i.ghost == '0) ? CoordW'(1) : CoordW'(cfg_i.ghost);
    x  = CoordW'(pos_x_q);
    y  = CoordW'(pos_y_q);
    z  = CoordW'(pos_z_q);
    cx = (cfg_i.rank == RANK_LINE) ? x - CoordW'(1) : x;
    cy = '0;
    cz = '0;
    if (cfg_i.rank == RANK_PLANE) begin
      cy = y - CoordW'(1);
    end else if (cfg_i.rank == RANK_VOLUME) begin
      cy = y;
      cz = z - CoordW'(1);
    end
    ix = in_span(cx, g, nx);
    iy = in_span(cy, g, ny);
    iz = in_span(cz, g, nz);

    s1_d           = s1_q;
    s1_d.rank      = cfg_i.rank;
    s1_d.row_start = (pos_x_q == '0);
    s1_d.px        = cx[4:0];
    s1_d.py        = cy[4:0];
    s1_d.pz        = cz[4:0];
    s1_d.sample    = in_req_i.sample_value;
    s1_d.lw0       = lw0_q;
    s1_d.lw1       = lw1_q;
    unique case (cfg_i.rank)
      RANK_LINE: begin
        s1_d.emit = (x != '0) && ix;
        s1_d.fin  = (cx + g + CoordW'(1)) == nx;
      end
      RANK_PLANE: begin
        s1_d.emit = (y != '0) && ix && iy;
        s1_d.fin  = ((cx + g + CoordW'(1)) == nx) && ((cy + g + CoordW'(1)) == ny);
      end
      RANK_VOLUME: begin
        s1_d.emit = (z != '0) && ix && iy && iz;
        s1_d.fin  = ((cx + g + CoordW'(1)) == nx) && ((cy + g + CoordW'(1)) == ny) &&
                    ((cz + g + CoordW'(1)) == nz);
      end
      default: begin
        s1_d.emit = 1'b0;
        s1_d.fin  = 1'b0;
      end
    endcase
  end

  always_comb begin
    pos_x_d = pos_x_q;
    pos_y_d = pos_y_q;
    pos_z_d = pos_z_q;
    if (accept) begin
      if (in_req_i.grid_end) begin
        pos_x_d = '0;
        pos_y_d = '0;
        pos_z_d = '0;
      end else if ((x + CoordW'(1)) >= nx) begin
        pos_x_d = '0;
        if ((y + CoordW'(1)) >= ny) begin
          pos_y_d = '0;
          if ((z + CoordW'(1)) >= nz) begin
            pos_z_d = '0;
          end else begin
            pos_z_d = ZW'(z + CoordW'(1));
          end
        end else begin
          pos_y_d = YW'(y + CoordW'(1));
        end
      end else begin
        pos_x_d = XW'(x + CoordW'(1));
      end
    end
  end

  always_comb begin
    xp1 = pos_x_q + XW'(1);
    ym1 = pos_y_q - YW'(1);
    ym2 = pos_y_q - YW'(2);
    yp1 = pos_y_q + YW'(1);
    zp  = ~pos_z_q[0];
    waddr_o      = {pos_z_q[0], pos_y_q, pos_x_q};
    raddr_back_o = {pos_z_q[0], pos_y_q, pos_x_q};
    if (cfg_i.rank == RANK_VOLUME) begin
      raddr_row_o = {zp, pos_y_q, xp1};
      raddr_alt_o = (pos_x_q == '0) ? {zp, pos_y_q, {XW{1'b0}}} : {zp, yp1, pos_x_q};
      raddr_ym_o  = {zp, ym1, pos_x_q};
    end else begin
      raddr_row_o = {1'b0, ym1, xp1};
      raddr_alt_o = {1'b0, ym1, {XW{1'b0}}};
      raddr_ym_o  = {1'b0, ym2, pos_x_q};
    end
  end

  assign ram_en_o   = accept;
  assign s1_valid_o = s1_valid_q;
  assign s1_o       = s1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_x_q    <= '0;
      pos_y_q    <= '0;
      pos_z_q    <= '0;
      lw0_q      <= '0;
      lw1_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      pos_x_q <= pos_x_d;
      pos_y_q <= pos_y_d;
      pos_z_q <= pos_z_d;
      if (accept) begin
        lw1_q <= lw0_q;
        lw0_q <= in_req_i.sample_value;
      end
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q <= s1_d;
    end
  end

endmodule

// ===== rtl/lss_datapath.sv =====
module lss_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lss_pkg::cfg_t     cfg_i,
  input  logic              s1_valid_i,
  input  lss_pkg::s1_t      s1_i,
  input  lss_pkg::rd_t      rd_i,
  output logic              s1_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output lss_pkg::out_req_t out_req_o
);
  import lss_pkg::*;

  typedef struct packed {
    logic [4:0] px;
    logic [4:0] py;
    logic [4:0] pz;
    logic       fin;
  } tag_t;

  function automatic logic signed [34:0] sec_diff(input logic signed [31:0] l,
                                                  input logic signed [31:0] c,
                                                  input logic signed [31:0] r);
    logic signed [34:0] le, ce, re;
    le = {{3{l[31]}}, l};
    ce = {{3{c[31]}}, c};
    re = {{3{r[31]}}, r};
    return le + re - (ce <<< 1);
  endfunction

  logic signed [31:0] win0_q, win1_q;
  logic signed [34:0] dx_d, dy_d, dz_d, dx_q, dy_q, dz_q;
  logic signed [51:0] hx_q, hy_q, hz_q, lx_q, ly_q, lz_q;
  logic signed [53:0] hs_q, ls_q;
  logic signed [54:0] t;
  logic signed [38:0] q;
  logic signed [55:0] r;
  logic signed [31:0] sat;
  tag_t tag2_q, tag3_q, tag4_q;
  logic v2_q, v3_q, v4_q, v5_q;
  logic rdy2, rdy3, rdy4, rdy5;
  out_req_t out_q;

  assign rdy5       = !v5_q || out_ready_i;
  assign rdy4       = !v4_q || rdy5;
  assign rdy3       = !v3_q || rdy4;
  assign rdy2       = !v2_q || rdy3;
  assign s1_ready_o = rdy2;

  always_comb begin
    dx_d = '0;
    dy_d = '0;
    dz_d = '0;
    unique case (s1_i.rank)
      RANK_LINE: begin
        dx_d = sec_diff(s1_i.lw1, s1_i.lw0, s1_i.sample);
      end
      RANK_PLANE: begin
        dx_d = sec_diff(win1_q, win0_q, rd_i.row);
        dy_d = sec_diff(rd_i.ym, win0_q, s1_i.sample);
      end
      RANK_VOLUME: begin
        dx_d = sec_diff(win1_q, win0_q, rd_i.row);
        dy_d = sec_diff(rd_i.ym, win0_q, rd_i.alt);
        dz_d = sec_diff(rd_i.back, win0_q, s1_i.sample);
      end
      default: begin
        dx_d = '0;
      end
    endcase
  end

  always_comb begin
    t = 55'(ls_q) + 55'sd32768;
    q = 39'(t >>> 16);
    r = 56'(hs_q) + 56'(q);
    if (r > 56'sd2147483647) begin
      sat = 32'sh7fffffff;
    end else if (r < -56'sd2147483648) begin
      sat = 32'sh80000000;
    end else begin
      sat = r[31:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (rdy2) begin
        v2_q <= s1_valid_i && s1_i.emit;
      end
      if (rdy3) begin
        v3_q <= v2_q;
      end
      if (rdy4) begin
        v4_q <= v3_q;
      end
      if (rdy5) begin
        v5_q <= v4_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_i && rdy2) begin
      if (s1_i.row_start) begin
        win0_q <= rd_i.row;
        win1_q <= rd_i.alt;
      end else begin
        win0_q <= rd_i.row;
        win1_q <= win0_q;
      end
      dx_q   <= dx_d;
      dy_q   <= dy_d;
      dz_q   <= dz_d;
      tag2_q <= '{px: s1_i.px, py: s1_i.py, pz: s1_i.pz, fin: s1_i.fin};
    end
    if (v2_q && rdy3) begin
      hx_q   <= dx_q * $signed({1'b0, cfg_i.coef_x[31:16]});
      hy_q   <= dy_q * $signed({1'b0, cfg_i.coef_y[31:16]});
      hz_q   <= dz_q * $signed({1'b0, cfg_i.coef_z[31:16]});
      lx_q   <= dx_q * $signed({1'b0, cfg_i.coef_x[15:0]});
      ly_q   <= dy_q * $signed({1'b0, cfg_i.coef_y[15:0]});
      lz_q   <= dz_q * $signed({1'b0, cfg_i.coef_z[15:0]});
      tag3_q <= tag2_q;
    end
    if (v3_q && rdy4) begin
      hs_q   <= 54'(hx_q) + 54'(hy_q) + 54'(hz_q);
      ls_q   <= 54'(lx_q) + 54'(ly_q) + 54'(lz_q);
      tag4_q <= tag3_q;
    end
    if (v4_q && rdy5) begin
      out_q.laplacian_value <= sat;
      out_q.point_x         <= tag4_q.px;
      out_q.point_y         <= tag4_q.py;
      out_q.point_z         <= tag4_q.pz;
      out_q.final_point     <= tag4_q.fin;
    end
  end

  assign out_valid_o = v5_q;
  assign out_req_o   = out_q;

endmodule

// ===== rtl/laplace_stencil_stream_unit.sv =====
// Each result is registered in the front, difference, product, sum and output stages in turn.
// One sample per cycle unless the output stalls; each sample costs one write and four store reads.
// Reset clears the grid position, the line window, the pipeline and sets the registers to
// their defaults; the plane store is not cleared and holds data only once written.
module laplace_stencil_stream_unit #(
  parameter int unsigned MAX_NX = lss_pkg::DefMaxNx,
  parameter int unsigned MAX_NY = lss_pkg::DefMaxNy,
  parameter int unsigned MAX_NZ = lss_pkg::DefMaxNz
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  lss_pkg::in_req_t              in_req_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output lss_pkg::out_req_t             out_req_o,
  input  logic                          cfg_wr_en_i,
  input  logic [lss_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [lss_pkg::CfgDataW-1:0]  cfg_wdata_i
);
  import lss_pkg::*;

  localparam int unsigned XW = $clog2(MAX_NX);
  localparam int unsigned YW = (MAX_NY > 1) ? $clog2(MAX_NY) : 1;
  localparam int unsigned AW = 1 + XW + YW;
  localparam int unsigned Depth = 2 ** AW;

  cfg_t cfg_q, cfg_d;
  logic s1_valid, s1_ready, ram_en;
  s1_t  s1;
  rd_t  rd;
  logic [AW-1:0] waddr, raddr_row, raddr_alt, raddr_ym, raddr_back;
  logic [31:0] rd_row, rd_alt, rd_ym, rd_back;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_wr_en_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_RANK:   cfg_d.rank   = rank_e'(cfg_wdata_i[1:0]);
        CFG_SIZE_X: cfg_d.size_x = cfg_wdata_i[5:0];
        CFG_SIZE_Y: cfg_d.size_y = cfg_wdata_i[5:0];
        CFG_SIZE_Z: cfg_d.size_z = cfg_wdata_i[5:0];
        CFG_GHOST:  cfg_d.ghost  = cfg_wdata_i[3:0];
        CFG_COEF_X: cfg_d.coef_x = cfg_wdata_i;
        CFG_COEF_Y: cfg_d.coef_y = cfg_wdata_i;
        CFG_COEF_Z: cfg_d.coef_z = cfg_wdata_i;
        default:    cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  lss_front #(
    .MAX_NX(MAX_NX),
    .MAX_NY(MAX_NY),
    .MAX_NZ(MAX_NZ),
    .AW    (AW)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .cfg_i       (cfg_q),
    .s1_ready_i  (s1_ready),
    .s1_valid_o  (s1_valid),
    .s1_o        (s1),
    .ram_en_o    (ram_en),
    .waddr_o     (waddr),
    .raddr_row_o (raddr_row),
    .raddr_alt_o (raddr_alt),
    .raddr_ym_o  (raddr_ym),
    .raddr_back_o(raddr_back)
  );

  lss_ram #(
    .Width(32),
    .Depth(Depth)
  ) u_ram_a (
    .clk_i    (clk_i),
    .we_i     (ram_en),
    .waddr_i  (waddr),
    .wdata_i  (in_req_i.sample_value),
    .re_i     (ram_en),
    .raddr_a_i(raddr_row),
    .raddr_b_i(raddr_alt),
    .rdata_a_o(rd_row),
    .rdata_b_o(rd_alt)
  );

  lss_ram #(
    .Width(32),
    .Depth(Depth)
  ) u_ram_b (
    .clk_i    (clk_i),
    .we_i     (ram_en),
    .waddr_i  (waddr),
    .wdata_i  (in_req_i.sample_value),
    .re_i     (ram_en),
    .raddr_a_i(raddr_ym),
    .raddr_b_i(raddr_back),
    .rdata_a_o(rd_ym),
    .rdata_b_o(rd_back)
  );

  assign rd = '{row: rd_row, alt: rd_alt, ym: rd_ym, back: rd_back};

  lss_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .s1_valid_i (s1_valid),
    .s1_i       (s1),
    .rd_i       (rd),
    .s1_ready_o (s1_ready),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_req_o  (out_req_o)
  );

endmodule

// ===== test/tb_laplace_stencil_stream_unit.sv =====
`timescale 1ns / 100ps

module tb_laplace_stencil_stream_unit;
  import lss_pkg::*;

  localparam int unsigned CycleLimit = 900000;
  localparam int unsigned SettleCycles = 12;
  localparam int unsigned HoldCycles = 400;

  class laplacian_scoreboard;
    rank_e       rank;
    int unsigned size_x, size_y, size_z, ghost;
    logic [31:0] coef_x, coef_y, coef_z;
    int          plane[2048];
    int          line_win[3];
    int unsigned pos_x, pos_y, pos_z;
    longint      acc_hi, acc_lo;
    out_req_t    due_points[$];
    int unsigned mismatches;

    function new();
      rank = RANK_VOLUME;
      size_x = 32;
      size_y = 32;
      size_z = 32;
      ghost = 1;
      coef_x = 32'd65536;
      coef_y = 32'd65536;
      coef_z = 32'd65536;
      foreach (plane[i]) plane[i] = 0;
      foreach (line_win[i]) line_win[i] = 0;
      pos_x = 0;
      pos_y = 0;
      pos_z = 0;
      mismatches = 0;
    endfunction

    function void write_reg(cfg_idx_e idx, logic [31:0] v);
      case (idx)
        CFG_RANK:   rank = rank_e'(v[1:0]);
        CFG_SIZE_X: size_x = v[5:0];
        CFG_SIZE_Y: size_y = v[5:0];
        CFG_SIZE_Z: size_z = v[5:0];
        CFG_GHOST:  ghost = v[3:0];
        CFG_COEF_X: coef_x = v;
        CFG_COEF_Y: coef_y = v;
        CFG_COEF_Z: coef_z = v;
        default: ;
      endcase
    endfunction

    function int unsigned clamp(int unsigned v, int unsigned lim);
      if (v < 1) return 1;
      if (v > lim) return lim;
      return v;
    endfunction

    function int unsigned dim_x();
      return clamp(size_x, 32);
    endfunction

    function int unsigned dim_y();
      return (rank >= RANK_PLANE) ? clamp(size_y, 32) : 1;
    endfunction

    function int unsigned dim_z();
      return (rank == RANK_VOLUME) ? clamp(size_z, 32) : 1;
    endfunction

    function longint rd(int x, int y, int z);
      if (x < 0 || x >= 32 || y < 0 || y >= 32) return 0;
      return plane[((z & 1) * 32 + y) * 32 + x];
    endfunction

    function void add_axis(longint l, longint c, longint r, logic [31:0] k);
      longint d;
      d = l + r - 2 * c;
      acc_hi += d * longint'(k[31:16]);
      acc_lo += d * longint'(k[15:0]);
    endfunction

    function bit interior(int c, int g, int n);
      return c >= g && c + g < n;
    endfunction

    function void note_sample(in_req_t r);
      longint s, c, res;
      int nx, ny, nz, g, x, y, z, cx, cy, cz;
      bit emit, fin;
      out_req_t p;
      s = longint'(r.sample_value);
      nx = dim_x();
      ny = dim_y();
      nz = dim_z();
      g = (ghost == 0) ? 1 : ghost;
      x = pos_x;
      y = pos_y;
      z = pos_z;
      cx = x;
      cy = 0;
      cz = 0;
      emit = 0;
      fin = 0;
      acc_hi = 0;
      acc_lo = 0;
      if (rank == RANK_LINE) begin
        if (x >= 1) begin
          cx = x - 1;
          if (interior(cx, g, nx)) begin
            emit = 1;
            add_axis(line_win[1], line_win[0], s, coef_x);
            fin = (cx + g + 1 == nx);
          end
        end
      end else if (rank == RANK_PLANE) begin
        if (y >= 1) begin
          cy = y - 1;
          if (interior(cx, g, nx) && interior(cy, g, ny)) begin
            c = rd(cx, cy, 0);
            emit = 1;
            add_axis(rd(cx - 1, cy, 0), c, rd(cx + 1, cy, 0), coef_x);
            add_axis(rd(cx, cy - 1, 0), c, s, coef_y);
            fin = (cx + g + 1 == nx) && (cy + g + 1 == ny);
          end
        end
      end else if (rank == RANK_VOLUME) begin
        cy = y;
        if (z >= 1) begin
          cz = z - 1;
          if (interior(cx, g, nx) && interior(cy, g, ny) && interior(cz, g, nz)) begin
            c = rd(cx, cy, cz);
            emit = 1;
            add_axis(rd(cx - 1, cy, cz), c, rd(cx + 1, cy, cz), coef_x);
            add_axis(rd(cx, cy - 1, cz), c, rd(cx, cy + 1, cz), coef_y);
            add_axis(rd(cx, cy, z), c, s, coef_z);
            fin = (cx + g + 1 == nx) && (cy + g + 1 == ny) && (cz + g + 1 == nz);
          end
        end
      end
      if (x < 32 && y < 32) plane[((z & 1) * 32 + y) * 32 + x] = int'(s);
      line_win[2] = line_win[1];
      line_win[1] = line_win[0];
      line_win[0] = int'(s);
      if (r.grid_end) begin
        pos_x = 0;
        pos_y = 0;
        pos_z = 0;
      end else begin
        pos_x = x + 1;
        if (pos_x >= nx) begin
          pos_x = 0;
          pos_y = y + 1;
          if (pos_y >= ny) begin
            pos_y = 0;
            pos_z = z + 1;
            if (pos_z >= nz) pos_z = 0;
          end
        end
      end
      if (emit) begin
        res = acc_hi + ((acc_lo + 32768) >>> 16);
        if (res > 64'sd2147483647) res = 64'sd2147483647;
        if (res < -64'sd2147483648) res = -64'sd2147483648;
        p.laplacian_value = res[31:0];
        p.point_x = cx[4:0];
        p.point_y = cy[4:0];
        p.point_z = cz[4:0];
        p.final_point = fin;
        due_points.push_back(p);
      end
    endfunction

    function void check_result(out_req_t a);
      out_req_t e;
      if (due_points.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result: expected none, got %p", a);
        return;
      end
      e = due_points.pop_front();
      if (a.laplacian_value !== e.laplacian_value || a.point_x !== e.point_x ||
          a.point_y !== e.point_y || a.point_z !== e.point_z ||
          a.final_point !== e.final_point) begin
        mismatches++;
        if (mismatches <= 10) $display("Result mismatch: expected %p, got %p", e, a);
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  in_req_t     in_req_i;
  logic        out_valid_o;
  logic        out_ready_i;
  out_req_t    out_req_o;
  logic        cfg_wr_en_i;
  logic [2:0]  cfg_index_i;
  logic [31:0] cfg_wdata_i;

  laplacian_scoreboard sb;
  int unsigned cycles = 0;
  int unsigned samples_sent;
  bit          no_gaps;
  bit          hold_req;

  laplace_stencil_stream_unit i_dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .in_req_i,
    .out_valid_o,
    .out_ready_i,
    .out_req_o,
    .cfg_wr_en_i,
    .cfg_index_i,
    .cfg_wdata_i
  );

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles == CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_result(out_req_o);
  end

  initial begin
    int unsigned stall;
    bit held;
    held = 0;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (hold_req && !held) begin
        held = 1;
        out_ready_i <= 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
      end
      stall = no_gaps ? 0 : $urandom_range(0, 19);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      @(negedge clk_i);
    end
  end

  task automatic send_sample(logic [31:0] v, logic last);
    int unsigned gap;
    in_req_t r;
    gap = no_gaps ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    r.sample_value = v;
    r.grid_end = last;
    in_valid_i <= 1'b1;
    in_req_i <= r;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_sample(r);
    samples_sent++;
    @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [31:0] v);
    cfg_wr_en_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    sb.write_reg(idx, v);
  endtask

  task automatic configure(rank_e rk, int unsigned nx, int unsigned ny, int unsigned nz,
                           int unsigned g, logic [31:0] kx, logic [31:0] ky,
                           logic [31:0] kz);
    write_reg(CFG_RANK, 32'(rk));
    write_reg(CFG_SIZE_X, nx);
    write_reg(CFG_SIZE_Y, ny);
    write_reg(CFG_SIZE_Z, nz);
    write_reg(CFG_GHOST, g);
    write_reg(CFG_COEF_X, kx);
    write_reg(CFG_COEF_Y, ky);
    write_reg(CFG_COEF_Z, kz);
    cfg_wr_en_i <= 1'b0;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.due_points.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  function automatic logic [31:0] draw_sample(bit wide);
    if (wide || $urandom_range(0, 9) == 0) return $urandom;
    return $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
  endfunction

  task automatic run_grid(bit wide);
    int unsigned n;
    bit with_end;
    n = sb.dim_x() * sb.dim_y() * sb.dim_z();
    with_end = $urandom_range(0, 9) != 0;
    for (int unsigned i = 0; i < n; i++) begin
      send_sample(draw_sample(wide), with_end && (i == n - 1));
    end
  endtask

  function automatic logic [31:0] draw_coef();
    case ($urandom_range(0, 4))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return 32'd65536;
      default: return $urandom_range(0, 32'h0004_0000);
    endcase
  endfunction

  initial begin
    rank_e rk;
    int unsigned nx, ny, nz, g;
    sb = new();
    samples_sent = 0;
    no_gaps = 0;
    hold_req = 0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_req_i = '0;
    cfg_wr_en_i = 1'b0;
    cfg_index_i = '0;
    cfg_wdata_i = '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Saturation on both sides along a single line.
    configure(RANK_LINE, 3, 1, 1, 0, 32'hFFFF_FFFF, 0, 0);
    send_sample(32'h7FFF_FFFF, 1'b0);
    send_sample(32'h8000_0000, 1'b0);
    send_sample(32'h7FFF_FFFF, 1'b1);
    send_sample(32'h8000_0000, 1'b0);
    send_sample(32'h7FFF_FFFF, 1'b0);
    send_sample(32'h8000_0000, 1'b1);
    drain();
    // No active axis: nothing comes out.
    configure(RANK_NONE, 4, 4, 4, 1, 65536, 65536, 65536);
    repeat (4) send_sample($urandom, 1'b0);
    drain();
    // A y size of zero leaves no interior.
    configure(RANK_PLANE, 4, 0, 1, 1, 65536, 65536, 65536);
    repeat (4) send_sample($urandom, 1'b0);
    drain();
    configure(RANK_PLANE, 3, 3, 1, 1, 0, 32'hFFFF_FFFF, 0);
    for (int i = 0; i < 9; i++) send_sample(draw_sample(1), i == 8);
    drain();

    // Largest coordinates on each axis, sizes above the maximum clamp to it.
    configure(RANK_LINE, 63, 5, 5, 15, 65536, 0, 0);
    run_grid(0);
    drain();
    configure(RANK_LINE, 32, 1, 1, 0, 32'h0002_8000, 0, 0);
    run_grid(0);
    drain();
    configure(RANK_PLANE, 4, 32, 1, 1, 65536, 32'h0001_8000, 0);
    run_grid(0);
    drain();
    hold_req = 1;
    configure(RANK_VOLUME, 32, 3, 3, 1, 65536, 65536, 65536);
    run_grid(0);
    drain();
    configure(RANK_VOLUME, 3, 3, 32, 1, 32'h0000_4000, 32'h0003_0000, $urandom);
    run_grid(0);
    drain();
    configure(RANK_VOLUME, 3, 32, 3, 1, 65536, 65536, 65536);
    run_grid(1);
    drain();

    while (samples_sent < 1400) begin
      rk = rank_e'($urandom_range(0, 12) == 0 ? 0 : $urandom_range(1, 3));
      g = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 2);
      case (rk)
        RANK_LINE: begin
          nx = $urandom_range(3, 32);
          ny = $urandom_range(0, 63);
          nz = $urandom_range(0, 63);
        end
        RANK_PLANE: begin
          nx = $urandom_range(3, 9);
          ny = $urandom_range(1, 9);
          nz = $urandom_range(0, 63);
        end
        default: begin
          nx = $urandom_range(3, 5);
          ny = $urandom_range(1, 5);
          nz = $urandom_range(1, 5);
        end
      endcase
      if ($urandom_range(0, 1)) g = (g > 1) ? g : $urandom_range(0, 1);
      no_gaps = $urandom_range(0, 3) == 0;
      configure(rk, nx, ny, nz, g, draw_coef(), draw_coef(), draw_coef());
      repeat ($urandom_range(1, 3)) run_grid($urandom_range(0, 2) == 0);
      drain();
    end

    if (sb.mismatches == 0 && sb.due_points.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
